FILE: hw/rtl/point_in_triangle_3d_test_macros.svh
// Assertion macros used by the top level of the point-in-triangle test.
`ifndef POINT_IN_TRIANGLE_3D_TEST_MACROS_SVH
`define POINT_IN_TRIANGLE_3D_TEST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pit assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define PIT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pit assertion failed (next cycle)");

`endif

FILE: hw/rtl/pit_pkg.sv
`timescale 1ns / 1ps

package pit_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int IN_W        = 16;
    localparam int VREG_W      = 48;
    localparam int VEXT_W      = 3 * COORD_WIDTH + VREG_W;
    localparam int TOL_W       = 16;
    localparam int TOL2_W      = 2 * TOL_W;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 48;

    localparam int DW    = COORD_WIDTH + 1;
    localparam int NPW   = 2 * DW;
    localparam int NW    = NPW + 1;
    localparam int MPW   = NW + DW;
    localparam int MW    = MPW + 1;
    localparam int ML    = MW / 2;
    localparam int MH    = MW - ML;
    localparam int PHW   = DW + MH;
    localparam int PLW   = DW + ML + 1;
    localparam int PW    = DW + MW;
    localparam int DDW   = PW + 2;
    localparam int NL    = NW / 2;
    localparam int NH    = NW - NL;
    localparam int NSQW  = 2 * NW;
    localparam int NNW   = NSQW + 2;
    localparam int LP    = (NNW + 2) / 3;
    localparam int LIMW  = TOL2_W + 3 * LP;
    localparam int SQW   = (LIMW + 1) / 2;
    localparam int SL    = SQW / 2;
    localparam int SH    = SQW - SL;
    localparam int CMPW  = 2 * SQW;

    localparam int NSTAGE    = 8;
    localparam int CFG_LAT   = 9;
    localparam int CFG_CNT_W = $clog2(CFG_LAT + 1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_VERTEX_A,
        REG_VERTEX_B,
        REG_VERTEX_C,
        REG_TOLERANCE
    } reg_index_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } point_t;

    typedef struct packed {
        logic signed [DW-1:0] z;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] x;
    } dvec_t;

    typedef struct packed {
        logic signed [NW-1:0] z;
        logic signed [NW-1:0] y;
        logic signed [NW-1:0] x;
    } nvec_t;

    typedef struct packed {
        logic signed [MW-1:0] z;
        logic signed [MW-1:0] y;
        logic signed [MW-1:0] x;
    } mvec_t;

    typedef struct packed {
        logic signed [IN_W-1:0] point_z;
        logic signed [IN_W-1:0] point_y;
        logic signed [IN_W-1:0] point_x;
    } in_t;

    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } out_t;

    typedef struct packed {
        point_t            va;
        point_t            vb;
        point_t            vc;
        mvec_t [2:0]       m;
        logic [LIMW-1:0]   lim;
        logic              degenerate;
        logic              busy;
    } cfg_t;

    typedef struct packed {
        logic [NSTAGE-1:0] en;
    } ctl_t;

    function automatic point_t unpack_vertex(logic [VREG_W-1:0] r);
        logic [VEXT_W-1:0] ext;
        point_t            p;
        ext = VEXT_W'(r);
        p.x = coord_t'(ext[COORD_WIDTH-1:0]);
        p.y = coord_t'(ext[2*COORD_WIDTH-1:COORD_WIDTH]);
        p.z = coord_t'(ext[3*COORD_WIDTH-1:2*COORD_WIDTH]);
        return p;
    endfunction

    function automatic coord_t coord_from_in(logic [IN_W-1:0] v);
        logic [COORD_WIDTH+IN_W-1:0] ext;
        ext = (COORD_WIDTH + IN_W)'(v);
        return coord_t'(ext[COORD_WIDTH-1:0]);
    endfunction

    function automatic dvec_t vsub(point_t p, point_t q);
        dvec_t r;
        r.x = DW'(p.x) - DW'(q.x);
        r.y = DW'(p.y) - DW'(q.y);
        r.z = DW'(p.z) - DW'(q.z);
        return r;
    endfunction

endpackage

FILE: hw/rtl/pit_cfg.sv
`timescale 1ns / 1ps

module pit_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [pit_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pit_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output pit_pkg::cfg_t                     cfg
);

    logic [pit_pkg::VREG_W-1:0]              va_reg;
    logic [pit_pkg::VREG_W-1:0]              vb_reg;
    logic [pit_pkg::VREG_W-1:0]              vc_reg;
    logic [pit_pkg::TOL_W-1:0]               tol_reg;
    logic [pit_pkg::CFG_CNT_W-1:0]           cnt_reg;

    pit_pkg::point_t                         va;
    pit_pkg::point_t                         vb;
    pit_pkg::point_t                         vc;

    pit_pkg::dvec_t                          e_reg [0:2];
    logic [pit_pkg::TOL2_W-1:0]              tol2_reg;
    logic signed [pit_pkg::NPW-1:0]          np_reg [0:5];
    pit_pkg::nvec_t                          n_reg;
    logic signed [pit_pkg::NW-1:0]           n_c [0:2];
    logic signed [pit_pkg::MPW-1:0]          mp_reg [0:2][0:5];
    logic [pit_pkg::NW-1:0]                  nabs_reg [0:2];
    pit_pkg::mvec_t                          m_reg [0:2];
    logic [2*pit_pkg::NH-1:0]                nhh_reg [0:2];
    logic [pit_pkg::NH+pit_pkg::NL-1:0]      nhl_reg [0:2];
    logic [2*pit_pkg::NL-1:0]                nll_reg [0:2];
    logic [pit_pkg::NSQW-1:0]                nsq_reg [0:2];
    logic [pit_pkg::NNW-1:0]                 nn_reg;
    logic [3*pit_pkg::LP-1:0]                nnp;
    logic [pit_pkg::TOL2_W+pit_pkg::LP-1:0]  lp_reg [0:2];
    logic                                    degen_reg;
    logic [pit_pkg::LIMW-1:0]                lim_reg;

    function automatic logic [pit_pkg::NW-1:0] mag_n(logic signed [pit_pkg::NW-1:0] v);
        return v[pit_pkg::NW-1] ? pit_pkg::NW'(-v) : pit_pkg::NW'(v);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg  <= '0;
            vb_reg  <= '0;
            vc_reg  <= '0;
            tol_reg <= pit_pkg::TOL_W'(1);
            cnt_reg <= pit_pkg::CFG_CNT_W'(pit_pkg::CFG_LAT);
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    pit_pkg::REG_VERTEX_A:  va_reg  <= cfg_wdata[pit_pkg::VREG_W-1:0];
                    pit_pkg::REG_VERTEX_B:  vb_reg  <= cfg_wdata[pit_pkg::VREG_W-1:0];
                    pit_pkg::REG_VERTEX_C:  vc_reg  <= cfg_wdata[pit_pkg::VREG_W-1:0];
                    pit_pkg::REG_TOLERANCE: tol_reg <= cfg_wdata[pit_pkg::TOL_W-1:0];
                    default: begin
                    end
                endcase
                cnt_reg <= pit_pkg::CFG_CNT_W'(pit_pkg::CFG_LAT);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_comb begin
        va     = pit_pkg::unpack_vertex(va_reg);
        vb     = pit_pkg::unpack_vertex(vb_reg);
        vc     = pit_pkg::unpack_vertex(vc_reg);
        n_c[0] = n_reg.x;
        n_c[1] = n_reg.y;
        n_c[2] = n_reg.z;
        nnp    = (3 * pit_pkg::LP)'(nn_reg);
    end

    // The derived values run freely off the registers; they settle within
    // the busy window that follows each write.
    always_ff @(posedge aclk) begin
        e_reg[0] <= pit_pkg::vsub(vb, va);
        e_reg[1] <= pit_pkg::vsub(vc, vb);
        e_reg[2] <= pit_pkg::vsub(va, vc);
        tol2_reg <= pit_pkg::TOL2_W'(tol_reg) * pit_pkg::TOL2_W'(tol_reg);

        np_reg[0] <= pit_pkg::NPW'(e_reg[2].y) * pit_pkg::NPW'(e_reg[0].z);
        np_reg[1] <= pit_pkg::NPW'(e_reg[2].z) * pit_pkg::NPW'(e_reg[0].y);
        np_reg[2] <= pit_pkg::NPW'(e_reg[2].z) * pit_pkg::NPW'(e_reg[0].x);
        np_reg[3] <= pit_pkg::NPW'(e_reg[2].x) * pit_pkg::NPW'(e_reg[0].z);
        np_reg[4] <= pit_pkg::NPW'(e_reg[2].x) * pit_pkg::NPW'(e_reg[0].y);
        np_reg[5] <= pit_pkg::NPW'(e_reg[2].y) * pit_pkg::NPW'(e_reg[0].x);

        n_reg.x <= pit_pkg::NW'(np_reg[0]) - pit_pkg::NW'(np_reg[1]);
        n_reg.y <= pit_pkg::NW'(np_reg[2]) - pit_pkg::NW'(np_reg[3]);
        n_reg.z <= pit_pkg::NW'(np_reg[4]) - pit_pkg::NW'(np_reg[5]);

        for (int i = 0; i < 3; i++) begin
            mp_reg[i][0] <= pit_pkg::MPW'(n_reg.y) * pit_pkg::MPW'(e_reg[i].z);
            mp_reg[i][1] <= pit_pkg::MPW'(n_reg.z) * pit_pkg::MPW'(e_reg[i].y);
            mp_reg[i][2] <= pit_pkg::MPW'(n_reg.z) * pit_pkg::MPW'(e_reg[i].x);
            mp_reg[i][3] <= pit_pkg::MPW'(n_reg.x) * pit_pkg::MPW'(e_reg[i].z);
            mp_reg[i][4] <= pit_pkg::MPW'(n_reg.x) * pit_pkg::MPW'(e_reg[i].y);
            mp_reg[i][5] <= pit_pkg::MPW'(n_reg.y) * pit_pkg::MPW'(e_reg[i].x);
            nabs_reg[i]  <= mag_n(n_c[i]);

            m_reg[i].x <= pit_pkg::MW'(mp_reg[i][0]) - pit_pkg::MW'(mp_reg[i][1]);
            m_reg[i].y <= pit_pkg::MW'(mp_reg[i][2]) - pit_pkg::MW'(mp_reg[i][3]);
            m_reg[i].z <= pit_pkg::MW'(mp_reg[i][4]) - pit_pkg::MW'(mp_reg[i][5]);
            nhh_reg[i] <= (2 * pit_pkg::NH)'(nabs_reg[i][pit_pkg::NW-1:pit_pkg::NL])
                        * (2 * pit_pkg::NH)'(nabs_reg[i][pit_pkg::NW-1:pit_pkg::NL]);
            nhl_reg[i] <= (pit_pkg::NH + pit_pkg::NL)'(nabs_reg[i][pit_pkg::NW-1:pit_pkg::NL])
                        * (pit_pkg::NH + pit_pkg::NL)'(nabs_reg[i][pit_pkg::NL-1:0]);
            nll_reg[i] <= (2 * pit_pkg::NL)'(nabs_reg[i][pit_pkg::NL-1:0])
                        * (2 * pit_pkg::NL)'(nabs_reg[i][pit_pkg::NL-1:0]);

            nsq_reg[i] <= (pit_pkg::NSQW'(nhh_reg[i]) << (2 * pit_pkg::NL))
                        + (pit_pkg::NSQW'(nhl_reg[i]) << (pit_pkg::NL + 1))
                        + pit_pkg::NSQW'(nll_reg[i]);
        end

        nn_reg <= pit_pkg::NNW'(nsq_reg[0]) + pit_pkg::NNW'(nsq_reg[1])
                + pit_pkg::NNW'(nsq_reg[2]);

        for (int j = 0; j < 3; j++) begin
            lp_reg[j] <= (pit_pkg::TOL2_W + pit_pkg::LP)'(tol2_reg)
                       * (pit_pkg::TOL2_W + pit_pkg::LP)'(nnp[j*pit_pkg::LP +: pit_pkg::LP]);
        end
        degen_reg <= (nn_reg == '0);

        lim_reg <= pit_pkg::LIMW'(lp_reg[0])
                 + (pit_pkg::LIMW'(lp_reg[1]) << pit_pkg::LP)
                 + (pit_pkg::LIMW'(lp_reg[2]) << (2 * pit_pkg::LP));
    end

    always_comb begin
        cfg.va         = va;
        cfg.vb         = vb;
        cfg.vc         = vc;
        cfg.m[0]       = m_reg[0];
        cfg.m[1]       = m_reg[1];
        cfg.m[2]       = m_reg[2];
        cfg.lim        = lim_reg;
        cfg.degenerate = degen_reg;
        cfg.busy       = (cnt_reg != '0);
    end

endmodule

FILE: hw/rtl/pit_edge.sv
`timescale 1ns / 1ps

module pit_edge (
    input  logic                        aclk,
    input  pit_pkg::ctl_t               ctl,
    input  pit_pkg::point_t             pt,
    input  pit_pkg::point_t             vs,
    input  pit_pkg::mvec_t              mv,
    input  logic [pit_pkg::LIMW-1:0]    lim,
    output logic                        fail
);

    pit_pkg::dvec_t                         t_reg;
    logic signed [pit_pkg::DW-1:0]          t_c [0:2];
    logic signed [pit_pkg::MW-1:0]          m_c [0:2];
    logic signed [pit_pkg::PHW-1:0]         ph_reg [0:2];
    logic signed [pit_pkg::PLW-1:0]         pl_reg [0:2];
    logic signed [pit_pkg::PW-1:0]          p_reg [0:2];
    logic signed [pit_pkg::DDW-1:0]         d_reg;
    logic                                   neg5_reg;
    logic [pit_pkg::DDW-1:0]                mag_reg;
    logic                                   neg6_reg;
    logic                                   big6_reg;
    logic [2*pit_pkg::SH-1:0]               hh_reg;
    logic [pit_pkg::SH+pit_pkg::SL-1:0]     hl_reg;
    logic [2*pit_pkg::SL-1:0]               ll_reg;
    logic                                   neg7_reg;
    logic                                   big7_reg;
    logic [pit_pkg::CMPW-1:0]               sq_reg;
    logic                                   fail_reg;

    always_comb begin
        t_c[0] = t_reg.x;
        t_c[1] = t_reg.y;
        t_c[2] = t_reg.z;
        m_c[0] = mv.x;
        m_c[1] = mv.y;
        m_c[2] = mv.z;
    end

    // The edge term is the triple product (P - S) . (N x E), with N x E
    // prepared on the configuration side.
    always_ff @(posedge aclk) begin
        if (ctl.en[0]) begin
            t_reg <= pit_pkg::vsub(pt, vs);
        end
        if (ctl.en[1]) begin
            for (int i = 0; i < 3; i++) begin
                ph_reg[i] <= pit_pkg::PHW'(t_c[i])
                           * pit_pkg::PHW'(signed'(m_c[i][pit_pkg::MW-1:pit_pkg::ML]));
                pl_reg[i] <= pit_pkg::PLW'(t_c[i])
                           * pit_pkg::PLW'(signed'({1'b0, m_c[i][pit_pkg::ML-1:0]}));
            end
        end
        if (ctl.en[2]) begin
            for (int i = 0; i < 3; i++) begin
                p_reg[i] <= (pit_pkg::PW'(ph_reg[i]) <<< pit_pkg::ML) + pit_pkg::PW'(pl_reg[i]);
            end
        end
        if (ctl.en[3]) begin
            d_reg <= pit_pkg::DDW'(p_reg[0]) + pit_pkg::DDW'(p_reg[1])
                   + pit_pkg::DDW'(p_reg[2]);
        end
        if (ctl.en[4]) begin
            neg5_reg <= d_reg[pit_pkg::DDW-1];
            mag_reg  <= d_reg[pit_pkg::DDW-1] ? pit_pkg::DDW'(-d_reg) : pit_pkg::DDW'(d_reg);
        end
        if (ctl.en[5]) begin
            neg6_reg <= neg5_reg;
            big6_reg <= |mag_reg[pit_pkg::DDW-1:pit_pkg::SQW];
            hh_reg   <= (2 * pit_pkg::SH)'(mag_reg[pit_pkg::SQW-1:pit_pkg::SL])
                      * (2 * pit_pkg::SH)'(mag_reg[pit_pkg::SQW-1:pit_pkg::SL]);
            hl_reg   <= (pit_pkg::SH + pit_pkg::SL)'(mag_reg[pit_pkg::SQW-1:pit_pkg::SL])
                      * (pit_pkg::SH + pit_pkg::SL)'(mag_reg[pit_pkg::SL-1:0]);
            ll_reg   <= (2 * pit_pkg::SL)'(mag_reg[pit_pkg::SL-1:0])
                      * (2 * pit_pkg::SL)'(mag_reg[pit_pkg::SL-1:0]);
        end
        if (ctl.en[6]) begin
            neg7_reg <= neg6_reg;
            big7_reg <= big6_reg;
            sq_reg   <= (pit_pkg::CMPW'(hh_reg) << (2 * pit_pkg::SL))
                      + (pit_pkg::CMPW'(hl_reg) << (pit_pkg::SL + 1))
                      + pit_pkg::CMPW'(ll_reg);
        end
        if (ctl.en[7]) begin
            fail_reg <= neg7_reg && (big7_reg || (sq_reg > pit_pkg::CMPW'(lim)));
        end
    end

    assign fail = fail_reg;

endmodule

FILE: hw/rtl/point_in_triangle_3d_test.sv
// Same-side point-in-triangle test in 3D. Vertices A, B, C and the tolerance
// are written through the configuration port; each input transaction carries
// one point and yields exactly one result transaction with inside_res and
// degenerate. The datapath is an eight-stage pipeline followed by an output
// register; a point is accepted every cycle unless the output stalls or the
// configuration is busy, and its result passes through the stage registers and
// the output register to m_valid. Bubbles are squeezed out under back-pressure.
// s_ready is low in the cycle of any configuration write and while the busy
// counter runs down after it and after reset, while the configuration pipeline
// derives the normal, an edge vector per side and the squared tolerance limit.
`timescale 1ns / 1ps
`include "point_in_triangle_3d_test_macros.svh"

module point_in_triangle_3d_test (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  pit_pkg::in_t                      s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output pit_pkg::out_t                     m_data,
    input  logic                              cfg_we,
    input  logic [pit_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pit_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    pit_pkg::cfg_t                 cfg;
    pit_pkg::ctl_t                 ctl;
    pit_pkg::point_t               pt;
    pit_pkg::point_t               vs [0:2];
    logic                          out_en;
    logic [pit_pkg::NSTAGE-1:0]    v_reg;
    logic                          m_valid_reg;
    pit_pkg::out_t                 m_data_reg;
    logic [2:0]                    fail;

    pit_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    always_comb begin
        out_en = !m_valid_reg || m_ready;
        ctl.en[pit_pkg::NSTAGE-1] = !v_reg[pit_pkg::NSTAGE-1] || out_en;
        for (int k = pit_pkg::NSTAGE - 2; k >= 0; k--) begin
            ctl.en[k] = !v_reg[k] || ctl.en[k+1];
        end
        s_ready = ctl.en[0] && !cfg.busy && !cfg_we;
        pt.x    = pit_pkg::coord_from_in(s_data.point_x);
        pt.y    = pit_pkg::coord_from_in(s_data.point_y);
        pt.z    = pit_pkg::coord_from_in(s_data.point_z);
        vs[0]   = cfg.va;
        vs[1]   = cfg.vb;
        vs[2]   = cfg.vc;
    end

    for (genvar i = 0; i < 3; i++) begin : g_edge
        pit_edge u_edge (
            .aclk (aclk),
            .ctl  (ctl),
            .pt   (pt),
            .vs   (vs[i]),
            .mv   (cfg.m[i]),
            .lim  (cfg.lim),
            .fail (fail[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctl.en[0]) begin
                v_reg[0] <= s_valid && s_ready;
            end
            for (int k = 1; k < pit_pkg::NSTAGE; k++) begin
                if (ctl.en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            if (out_en) begin
                m_valid_reg <= v_reg[pit_pkg::NSTAGE-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            m_data_reg.inside_res <= ~|fail;
            m_data_reg.degenerate <= cfg.degenerate;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PIT_ASSERT_NXT(a_busy_after_write, aclk, aresetn, cfg_we, !s_ready)
    `PIT_ASSERT_NXT(a_accept_fills_first, aclk, aresetn, s_valid && s_ready, v_reg[0])
    `PIT_ASSERT_NXT(a_tail_held_on_stall, aclk, aresetn, v_reg[pit_pkg::NSTAGE-1] && !out_en, v_reg[pit_pkg::NSTAGE-1])

endmodule
